[design/ccw_pkg.sv]
// ----------------------------------------------------------------------------
// ccw_pkg
// shared types and constants of the coin change way counter
// ----------------------------------------------------------------------------
package ccw_pkg;

	localparam int SUM_W  = 6;
	localparam int COIN_W = 8;
	localparam int OUT_W  = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_FLUSH,
		ST_READ,
		ST_DRAIN
	} ccw_state_t;

endpackage

[design/ccw_ram.sv]
// ----------------------------------------------------------------------------
// ccw_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ccw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic [WIDTH-1:0]         rd_a_data,
	output logic [WIDTH-1:0]         rd_b_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_data <= mem_q[rd_a_addr];
			rd_b_data <= mem_q[rd_b_addr];
		end
	end

endmodule

[design/coin_change_way_counter_unit.sv]
// ----------------------------------------------------------------------------
// coin_change_way_counter_unit
// counts unordered ways to form each sum 0..target from a set of coin values
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): one coin word per job step, last_coin
// closes the set. output channel (out_valid/out_ready): one word per sum
// 0..target after the last coin, last_result on the word for the target.
// cfg_we/cfg_wdata write target_sum at once; write it only while idle.
// a nonzero coin c <= target is folded one table entry per cycle, sum c up to
// the target, through the two-read, one-write table memory, and a flush state
// then retires the last write before the next coin is taken.
// a zero coin or one above the target is taken without a fold.
// the readout issues one table read per cycle, so target + 1 words leave at
// one per cycle; a stalled receiver holds the output register and the readout
// waits behind it.
// a new coin is accepted while the final word still waits in the output
// register. the table is reset to one at sum zero and zero elsewhere by
// per-entry valid flags, cleared at reset and after each readout, so no
// clearing pass is needed. counts saturate at the counter maximum.
// ----------------------------------------------------------------------------
module coin_change_way_counter_unit
	import ccw_pkg::*;
#(
	parameter int MAX_SUM     = 63,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SUM_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [COIN_W-1:0] coin_value,
	input  logic              last_coin,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SUM_W-1:0]  sum_index,
	output logic [OUT_W-1:0]  way_count,
	output logic              last_result
);

	localparam int DEPTH = MAX_SUM + 1;
	localparam int AW    = $clog2(DEPTH);

	ccw_state_t state_q, state_d;

	logic [SUM_W-1:0]       target_q;
	logic [AW-1:0]          t_eff;
	logic [AW-1:0]          t_q;
	logic [AW-1:0]          coin_q;
	logic                   last_q;
	logic [AW-1:0]          j_q;
	logic [DEPTH-1:0]       valid_q;

	logic                   accept;
	logic                   fold_ok;
	logic                   rd_en;
	logic [AW-1:0]          rd_a_addr;
	logic [AW-1:0]          rd_b_addr;
	logic [COUNT_WIDTH-1:0] rd_a_data;
	logic [COUNT_WIDTH-1:0] rd_b_data;

	logic                   fold_s1;
	logic                   rd_vld_s1;
	logic [AW-1:0]          a_s1;
	logic [AW-1:0]          b_s1;
	logic                   vld_a_s1;
	logic                   vld_b_s1;

	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   wr_vld_q;
	logic [AW-1:0]          wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;

	logic [COUNT_WIDTH-1:0] a_val;
	logic [COUNT_WIDTH-1:0] b_val;
	logic [COUNT_WIDTH:0]   sum_wide;
	logic [63:0]            a_ext;
	logic                   load;
	logic                   issue;

	logic                   out_valid_q;
	logic [SUM_W-1:0]       sum_index_q;
	logic [OUT_W-1:0]       way_count_q;
	logic                   last_result_q;

	// effective target and coin checks
	always_comb begin
		if (target_q > SUM_W'(MAX_SUM)) begin
			t_eff = AW'(MAX_SUM);
		end else begin
			t_eff = target_q[AW-1:0];
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fold_ok  = (coin_value != '0) && (coin_value <= COIN_W'(t_eff));

	// readout handoff into the output register
	assign load  = rd_vld_s1 && (!out_valid_q || out_ready);
	assign issue = (state_q == ST_READ) && (!rd_vld_s1 || load);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (fold_ok) begin
						state_d = ST_FOLD;
					end else if (last_coin) begin
						state_d = ST_READ;
					end
				end
			end
			ST_FOLD: begin
				if (j_q == t_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = last_q ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				if (issue && (j_q == t_q)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 || load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory read issue
	always_comb begin
		rd_en     = 1'b0;
		rd_a_addr = j_q;
		rd_b_addr = j_q - coin_q;
		unique case (state_q)
			ST_FOLD:  rd_en = 1'b1;
			ST_READ:  rd_en = issue;
			ST_IDLE,
			ST_FLUSH,
			ST_DRAIN: rd_en = 1'b0;
			default:  rd_en = 1'b0;
		endcase
	end

	ccw_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (a_s1),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	// entries never written since clear read as one at sum zero, else zero
	always_comb begin
		if (vld_a_s1) begin
			a_val = rd_a_data;
		end else begin
			a_val = (a_s1 == '0) ? COUNT_WIDTH'(1) : '0;
		end
		priority if (wr_vld_q && (wr_addr_q == b_s1)) begin
			b_val = wr_data_q;
		end else if (vld_b_s1) begin
			b_val = rd_b_data;
		end else begin
			b_val = (b_s1 == '0) ? COUNT_WIDTH'(1) : '0;
		end
	end

	assign sum_wide = {1'b0, a_val} + {1'b0, b_val};
	assign wr_data  = sum_wide[COUNT_WIDTH] ? '1 : sum_wide[COUNT_WIDTH-1:0];
	assign wr_en    = fold_s1;
	assign a_ext    = 64'(a_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= '0;
			j_q         <= '0;
			valid_q     <= '0;
			fold_s1     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			wr_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			fold_s1  <= (state_q == ST_FOLD);
			wr_vld_q <= wr_en;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (accept) begin
				last_q <= last_coin;
				j_q    <= fold_ok ? coin_value[AW-1:0] : '0;
			end else if (state_q == ST_FOLD) begin
				j_q <= (j_q == t_q) ? '0 : j_q + AW'(1);
			end else if (issue) begin
				j_q <= j_q + AW'(1);
			end
			if (wr_en) begin
				valid_q[a_s1] <= 1'b1;
			end
			if (issue && (j_q == t_q)) begin
				valid_q <= '0;
			end
			if (issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (load) begin
				rd_vld_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q    <= t_eff;
			coin_q <= coin_value[AW-1:0];
		end
		if (rd_en) begin
			a_s1     <= rd_a_addr;
			b_s1     <= rd_b_addr;
			vld_a_s1 <= valid_q[rd_a_addr];
			vld_b_s1 <= valid_q[rd_b_addr];
		end
		wr_addr_q <= a_s1;
		wr_data_q <= wr_data;
		if (load) begin
			sum_index_q   <= SUM_W'(a_s1);
			way_count_q   <= (a_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : a_ext[OUT_W-1:0];
			last_result_q <= (a_s1 == t_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign sum_index   = sum_index_q;
	assign way_count   = way_count_q;
	assign last_result = last_result_q;

endmodule

[bench/tb_coin_change_way_counter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coin_change_way_counter_unit
// self-checking bench for the coin change way counter
// ----------------------------------------------------------------------------
// a directed table covers zero coins, coins above the target, the largest
// and smallest targets, a target moved in the middle of a job and a count
// that saturates, then random jobs of one to five coins run under several
// target settings and four idling patterns on both channels. every output
// word is checked field by field against a bit-accurate way table kept in
// the bench.
// ----------------------------------------------------------------------------
module tb_coin_change_way_counter_unit;
	import ccw_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;
	localparam int SETTLE      = 70;
	localparam int PHASES      = 8;
	localparam int PHASE_COINS = 16;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [OUT_W-1:0] count;
		logic             last;
	} way_word_t;

	typedef enum logic {
		ROW_COIN,
		ROW_TARGET
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [COIN_W-1:0] value;
		logic              last;
		logic              typed;
		logic [OUT_W-1:0]  typed_count;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [SUM_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [COIN_W-1:0] coin_value = '0;
	logic              last_coin = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [SUM_W-1:0]  sum_index;
	logic [OUT_W-1:0]  way_count;
	logic              last_result;

	logic [OUT_W-1:0]  ways [0:63];
	logic [SUM_W-1:0]  target_now;
	way_word_t         expected_words [$];
	way_word_t         head_word;
	stim_row_t         plan [$];

	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	int errors = 0;
	int cycles = 0;
	int coins_sent = 0;
	int words_checked = 0;
	int saturated_words = 0;
	int targets_set = 0;

	coin_change_way_counter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coin_value (coin_value),
		.last_coin  (last_coin),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sum_index  (sum_index),
		.way_count  (way_count),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ways();
		for (int j = 0; j < 64; j++) ways[j] = '0;
		ways[0] = 1;
	endfunction

	// fold one coin into the way table, queue the readout on the last coin
	function automatic void fold_coin(input logic [COIN_W-1:0] c, input logic l);
		logic [OUT_W:0] s;
		way_word_t w;
		int ci;
		int tn;
		ci = int'(c);
		tn = int'(target_now);
		if (ci != 0 && ci <= tn) begin
			for (int j = ci; j <= tn; j++) begin
				s = {1'b0, ways[j]} + {1'b0, ways[j-ci]};
				ways[j] = s[OUT_W] ? '1 : s[OUT_W-1:0];
			end
		end
		if (l) begin
			for (int j = 0; j <= tn; j++) begin
				w.sum = SUM_W'(j);
				w.count = ways[j];
				w.last = (j == tn);
				expected_words.push_back(w);
			end
			clear_ways();
		end
	endfunction

	task automatic send_coin(input logic [COIN_W-1:0] c, input logic l,
			input logic typed, input logic [OUT_W-1:0] typed_count);
		way_word_t w;
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coin_value <= c;
		last_coin <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fold_coin(c, l);
		coins_sent++;
		if (typed) begin
			w = expected_words.pop_back();
			w.count = typed_count;
			expected_words.push_back(w);
		end
	endtask

	task automatic hold_and_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic set_target(input logic [SUM_W-1:0] v);
		hold_and_drain();
		// a non-last coin gives no word, so let any fold finish
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		target_now = v;
		targets_set++;
	endtask

	// output side: check each word and stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word sum_index %0d way_count %0d last_result %0d",
						$time, sum_index, way_count, last_result);
				end else begin
					head_word = expected_words.pop_front();
					words_checked++;
					if (way_count == '1) saturated_words++;
					if (sum_index !== head_word.sum) begin
						errors++;
						$display("%0t: sum_index expected %0d actual %0d",
							$time, head_word.sum, sum_index);
					end
					if (way_count !== head_word.count) begin
						errors++;
						$display("%0t: way_count at sum %0d expected %0d actual %0d",
							$time, head_word.sum, head_word.count, way_count);
					end
					if (last_result !== head_word.last) begin
						errors++;
						$display("%0t: last_result at sum %0d expected %0d actual %0d",
							$time, head_word.sum, head_word.last, last_result);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : main_seq
		int n;
		int r;
		int sent_in_phase;
		int job;
		logic [COIN_W-1:0] c;
		logic [SUM_W-1:0] t;

		clear_ways();
		target_now = '0;
		plan = '{
			'{ROW_COIN,   8'd0,   1'b1, 1'b1, 32'd1},
			'{ROW_COIN,   8'd255, 1'b1, 1'b1, 32'd1},
			'{ROW_COIN,   8'd128, 1'b1, 1'b1, 32'd1},
			'{ROW_TARGET, 8'd63,  1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b1, 1'b1, 32'hFFFF_FFFF},
			'{ROW_COIN,   8'd63,  1'b1, 1'b1, 32'd1},
			'{ROW_COIN,   8'd64,  1'b1, 1'b1, 32'd0},
			'{ROW_TARGET, 8'd5,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd0,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd2,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd5,   1'b1, 1'b1, 32'd4},
			'{ROW_TARGET, 8'd10,  1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd3,   1'b0, 1'b0, 32'd0},
			'{ROW_TARGET, 8'd20,  1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd7,   1'b1, 1'b0, 32'd0},
			'{ROW_TARGET, 8'd0,   1'b0, 1'b0, 32'd0},
			'{ROW_COIN,   8'd1,   1'b1, 1'b1, 32'd1}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_TARGET)
				set_target(plan[i].value[SUM_W-1:0]);
			else
				send_coin(plan[i].value, plan[i].last, plan[i].typed, plan[i].typed_count);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			unique case (ph % 4)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 52; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 52; end
				default: begin tx_gap_pct = 13; rx_stall_pct = 13; end
			endcase
			if (ph == 0 || ph == 5)
				t = SUM_W'(63);
			else if (ph == 1)
				t = '0;
			else
				t = SUM_W'($urandom_range(63));
			set_target(t);
			sent_in_phase = 0;
			job = 0;
			while (sent_in_phase < PHASE_COINS) begin
				if (ph == 2 && job == 1)
					hold_and_drain();
				n = $urandom_range(5, 1);
				for (int k = 0; k < n; k++) begin
					r = $urandom_range(99);
					if (r < 80 && target_now != 0)
						c = COIN_W'($urandom_range(int'(target_now), 1));
					else if (r < 88)
						c = '0;
					else
						c = COIN_W'($urandom_range(255));
					send_coin(c, k == n - 1, 1'b0, '0);
					sent_in_phase++;
				end
				job++;
			end
		end

		hold_and_drain();
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d coins under %0d target settings and four idling patterns",
			coins_sent, targets_set);
		$display("checked %0d words, %0d of them saturated", words_checked, saturated_words);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
